@@ rtl/core/cmi_pkg.sv @@
// ---------------------------------------------------------------------------
// cmi_pkg : shared types and constants for the complex matrix inverse
// Sizes, payload structs, controller states and datapath command codes.
// ---------------------------------------------------------------------------
package cmi_pkg;

   localparam int SIZE      = 4;
   localparam int FRAC_BITS = 16;
   localparam int NELEM     = SIZE * SIZE;
   localparam int NCOL      = 2 * SIZE;
   localparam int DEPTH     = SIZE * NCOL;
   localparam int RW        = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int CW        = $clog2(NCOL);
   localparam int AW        = $clog2(DEPTH);
   localparam int LW        = $clog2(NELEM + 1);

   typedef struct packed {
      logic signed [31:0] elem_real;
      logic signed [31:0] elem_imag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_real;
      logic signed [31:0] out_imag;
      logic               out_last;
      logic               singular;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_IDENT,
      OP_SCALE,
      OP_SUB,
      OP_MULSUB,
      OP_EMIT
   } op_type;

   // sequencer phases
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_IDENT,
      ST_SCALE_T,
      ST_SCALE,
      ST_SUB,
      ST_MS_T,
      ST_MULSUB,
      ST_EMIT,
      ST_WAIT
   } state_type;

   // command from controller to datapath
   typedef struct packed {
      op_type          op;
      logic [RW-1:0]   row;     // target row
      logic [RW-1:0]   src;     // pivot / source row
      logic [CW-1:0]   col;     // element column
      logic [CW-1:0]   pcol;    // column holding the factor
      logic            get_t;   // fetch the factor into t
      logic            last;    // last emitted element
   } cmd_type;

   typedef struct packed {
      logic done;      // element operation finished
      logic t_zero;    // factor register holds 0+0i
   } sts_type;

endpackage

@@ rtl/core/complex_matrix_inverse.sv @@
// ---------------------------------------------------------------------------
// complex_matrix_inverse : Gauss-Jordan inverse of a complex matrix
// Loads SIZE*SIZE elements, eliminates in place, streams out the inverse.
// ---------------------------------------------------------------------------
//  channel   ports                         direction
//  request   start, busy, req_data         in  (accepted on start & !busy)
//  result    rsp_strobe, rsp_data          out (one cycle per element)
//
//  Loading accepts one request per cycle. After the last request the sequencer
//  runs elimination; each scaled element needs two quotients from the serial
//  divider, and each multiply-subtract four products. Results then stream out
//  in row order. Reset is synchronous and clears the control state, not the
//  stores; the receiver cannot stall.
module complex_matrix_inverse (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cmi_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output cmi_pkg::rsp_type  rsp_data
);
   import cmi_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    cmd_go, sing;

   cmi_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .busy(busy),
      .cmd_go(cmd_go), .cmd(cmd), .sing(sing)
   );

   cmi_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_go(cmd_go),
      .req_data(req_data), .sing(sing), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

`ifndef SYNTH
   a_no_rsp_when_loading : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while accepting requests");
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.out_last) |=> !rsp_strobe)
      else $error("result after last element");
`endif
endmodule

@@ rtl/core/cmi_divider.sv @@
// ---------------------------------------------------------------------------
// cmi_divider : restoring divider, one quotient bit per cycle
// Computes trunc(n * 2^F / d), quotient clamped to 2^32, 128 steps.
// ---------------------------------------------------------------------------
module cmi_divider (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [63:0]  num,
   input  logic [63:0]  den,
   output logic         done,
   output logic [32:0]  quo
);
   import cmi_pkg::*;

   logic [127:0] sh_ff, sh_in;
   logic [64:0]  rem_ff, rem_in;
   logic [63:0]  den_ff, den_in;
   logic [32:0]  q_ff, q_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in, done_ff, done_in;
   logic [65:0]  trial;
   logic [33:0]  qs;

   always_comb begin
      sh_in = sh_ff; rem_in = rem_ff; den_in = den_ff; q_in = q_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = '0; qs = '0;
      if (go) begin
         sh_in  = {64'd0, num} << FRAC_BITS;
         rem_in = '0; q_in = '0; den_in = den;
         cnt_in = 8'd0; run_in = 1'b1;
      end else if (run_ff) begin
         trial = {rem_ff, sh_ff[127]};
         qs = {q_ff, 1'b0};
         if (trial >= {2'b00, den_ff}) begin
            trial = trial - {2'b00, den_ff};
            qs[0] = 1'b1;
         end
         rem_in = trial[64:0];
         q_in = (qs > 34'h1_0000_0000) ? 33'h1_0000_0000 : qs[32:0];
         sh_in = {sh_ff[126:0], 1'b0};
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == 8'd127) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      sh_ff <= sh_in; rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

@@ rtl/core/cmi_datapath.sv @@
// ---------------------------------------------------------------------------
// cmi_datapath : augmented store and complex arithmetic
// One element per command; products are taken one per cycle on a shared
// 32x32 multiplier, divisions go through one serial divider.
// ---------------------------------------------------------------------------
module cmi_datapath (
   input  logic              clock,
   input  logic              reset,
   input  cmi_pkg::cmd_type  cmd,
   input  logic              cmd_go,
   input  cmi_pkg::req_type  req_data,
   input  logic              sing,
   output cmi_pkg::sts_type  sts,
   output logic              rsp_strobe,
   output cmi_pkg::rsp_type  rsp_data
);
   import cmi_pkg::*;

   typedef enum logic [3:0] {
      P_IDLE, P_RD1, P_RD2, P_RDW, P_M0, P_M1, P_M2, P_M3, P_M4,
      P_DEN, P_DR, P_DI, P_WR, P_TF
   } ph_type;

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_ff;
   logic [AW-1:0] ra;
   logic        re;
   logic [AW-1:0] wa;
   logic        we;
   logic [63:0] wd;

   ph_type ph_ff, ph_in;
   cmd_type c_ff, c_in;
   logic signed [31:0] tr_ff, tr_in, ti_ff, ti_in;
   logic signed [31:0] ar_ff, ar_in, ai_ff, ai_in;
   logic signed [31:0] xr_ff, xr_in, xi_ff, xi_in;
   logic signed [63:0] p_ff [4];
   logic signed [63:0] p_in;
   logic [1:0]  pi_ff, pi_in;
   logic        mwr;
   logic signed [31:0] ma, mb;
   logic [63:0] d_ff, d_in;
   logic signed [31:0] rr_ff, rr_in;
   logic        dgo;
   logic [63:0] dnum;
   logic        ddone;
   logic [32:0] dq;
   logic        dneg_ff, dneg_in;
   logic        st_done;
   logic        o_stb_ff, o_stb_in;
   rsp_type     o_ff, o_in;
   logic [64:0] s1_ff, s1_in;

   cmi_divider u_div (
      .clock(clock), .reset(reset), .go(dgo), .num(dnum), .den(d_ff),
      .done(ddone), .quo(dq)
   );

   function automatic logic [64:0] smsum(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
      logic [63:0] ma_, mb_;
      logic        na, nb;
      na = a[63]; nb = b[63];
      ma_ = na ? 64'd0 - 64'(a) : 64'(a);
      mb_ = nb ? 64'd0 - 64'(b) : 64'(b);
      if (na == nb) smsum = {na, ma_ + mb_};
      else if (ma_ >= mb_) smsum = {na, ma_ - mb_};
      else smsum = {nb, mb_ - ma_};
   endfunction

   function automatic logic signed [31:0] smap(input logic neg, input logic [63:0] q);
      if (neg) smap = (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q);
      else smap = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      if (d > 33'sh0_7FFF_FFFF) sat_sub = 32'sh7FFF_FFFF;
      else if (d < -33'sh0_8000_0000) sat_sub = 32'sh8000_0000;
      else sat_sub = d[31:0];
   endfunction

   function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      addr = AW'(r * NCOL + c);
   endfunction

   logic [64:0] sm_a, sm_b;

   always_comb begin
      ph_in = ph_ff; c_in = c_ff;
      tr_in = tr_ff; ti_in = ti_ff; ar_in = ar_ff; ai_in = ai_ff;
      xr_in = xr_ff; xi_in = xi_ff; pi_in = pi_ff; d_in = d_ff; rr_in = rr_ff;
      dneg_in = dneg_ff; s1_in = s1_ff;
      ra = '0; re = 1'b0; wa = addr(c_ff.row, c_ff.col); we = 1'b0; wd = '0;
      mwr = 1'b0; ma = '0; mb = '0; dgo = 1'b0; dnum = '0; st_done = 1'b0;
      o_stb_in = 1'b0; o_in = o_ff;
      sm_a = smsum(p_ff[0], -p_ff[1]);
      sm_b = smsum(p_ff[2], p_ff[3]);
      unique case (ph_ff)
         P_IDLE: begin
            if (cmd_go) begin
               c_in = cmd;
               unique case (cmd.op)
                  OP_LOAD: begin
                     we = 1'b1; wa = addr(cmd.row, cmd.col);
                     wd = {req_data.elem_real, req_data.elem_imag};
                     st_done = 1'b1;
                  end
                  OP_IDENT: begin
                     we = 1'b1; wa = addr(cmd.row, cmd.col);
                     wd = {((CW'(SIZE) + CW'(cmd.row)) == cmd.col) ?
                           32'(1 << FRAC_BITS) : 32'd0, 32'd0};
                     st_done = 1'b1;
                  end
                  OP_NONE: st_done = 1'b1;
                  default: begin
                     re = 1'b1;
                     ra = cmd.get_t ? addr(cmd.row, cmd.pcol) : addr(cmd.row, cmd.col);
                     ph_in = P_RD1;
                  end
               endcase
            end
         end
         P_RD1: begin
            if (c_ff.get_t) begin
               tr_in = rd_ff[63:32]; ti_in = rd_ff[31:0];
               ph_in = P_TF;
            end else begin
               ar_in = rd_ff[63:32]; ai_in = rd_ff[31:0];
               // issue second read
               re = 1'b1;
               ra = addr(c_ff.src, c_ff.col);
               ph_in = P_RD2;
            end
         end
         P_RD2: begin
            ph_in = P_RDW;
         end
         P_TF: begin
            st_done = 1'b1; ph_in = P_IDLE;
         end
         P_RDW: begin
            xr_in = rd_ff[63:32]; xi_in = rd_ff[31:0];
            pi_in = 2'd0;
            unique case (c_ff.op)
               OP_SUB: begin
                  we = 1'b1;
                  wd = {sat_sub(ar_ff, rd_ff[63:32]), sat_sub(ai_ff, rd_ff[31:0])};
                  st_done = 1'b1; ph_in = P_IDLE;
               end
               OP_EMIT: begin
                  o_stb_in = 1'b1;
                  o_in.out_real = ar_ff; o_in.out_imag = ai_ff;
                  o_in.out_last = c_ff.last; o_in.singular = sing;
                  st_done = 1'b1; ph_in = P_IDLE;
               end
               default: ph_in = P_M0;
            endcase
         end
         P_M0, P_M1, P_M2, P_M3: begin
            // scale: a*t products; mulsub: t*x products
            mwr = 1'b1;
            unique case (pi_ff)
               2'd0: begin
                  ma = (c_ff.op == OP_SCALE) ? ar_ff : tr_ff;
                  mb = (c_ff.op == OP_SCALE) ? tr_ff : xr_ff;
               end
               2'd1: begin
                  ma = (c_ff.op == OP_SCALE) ? ai_ff : ti_ff;
                  mb = (c_ff.op == OP_SCALE) ? ti_ff : xi_ff;
               end
               2'd2: begin
                  ma = (c_ff.op == OP_SCALE) ? ai_ff : tr_ff;
                  mb = (c_ff.op == OP_SCALE) ? tr_ff : xi_ff;
               end
               default: begin
                  ma = (c_ff.op == OP_SCALE) ? ar_ff : ti_ff;
                  mb = (c_ff.op == OP_SCALE) ? ti_ff : xr_ff;
               end
            endcase
            pi_in = pi_ff + 2'd1;
            ph_in = (ph_ff == P_M3) ? P_M4 : ph_type'(ph_ff + 4'd1);
         end
         P_M4: begin
            if (c_ff.op == OP_SCALE) begin
               // re num = ar*tr + ai*ti ; im num = ai*tr - ar*ti
               s1_in = smsum(p_ff[2], -p_ff[3]);
               ph_in = P_DEN;
            end else begin
               we = 1'b1;
               wd = {sat_sub(ar_ff, smap(sm_a[64], sm_a[63:0] >> FRAC_BITS)),
                     sat_sub(ai_ff, smap(sm_b[64], sm_b[63:0] >> FRAC_BITS))};
               st_done = 1'b1; ph_in = P_IDLE;
            end
         end
         P_DEN: begin
            // denominator from t squares into slots 2 and 3
            mwr = 1'b1; ma = tr_ff; mb = tr_ff; pi_in = 2'd0;
            d_in = '0;
            ph_in = P_DR;
            dgo = 1'b0;
         end
         P_DR: begin
            if (pi_ff == 2'd0) begin
               mwr = 1'b1; ma = ti_ff; mb = ti_ff; pi_in = 2'd1;
            end else if (pi_ff == 2'd1) begin
               d_in = 64'(p_ff[2]) + 64'(p_ff[3]);
               pi_in = 2'd2;
            end else if (pi_ff == 2'd2) begin
               dgo = 1'b1;
               {dneg_in, dnum} = smsum(p_ff[0], p_ff[1]);
               pi_in = 2'd3;
            end else if (ddone) begin
               rr_in = smap(dneg_ff, {31'd0, dq});
               dgo = 1'b1; {dneg_in, dnum} = s1_ff;
               ph_in = P_DI;
            end
         end
         P_DI: begin
            if (ddone) begin
               we = 1'b1;
               wd = {rr_ff, smap(dneg_ff, {31'd0, dq})};
               st_done = 1'b1; ph_in = P_IDLE;
            end
         end
         default: ph_in = P_IDLE;
      endcase
   end

   // product register file: M0..M3 fill slots 0..3; denominator uses 2,3
   logic [1:0] pslot;
   always_comb begin
      p_in = ma * mb;
      pslot = (ph_ff == P_DEN) ? 2'd2 : (ph_ff == P_DR) ? 2'd3 : pi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= P_IDLE; o_stb_ff <= 1'b0; pi_ff <= '0;
      end else begin
         ph_ff <= ph_in; o_stb_ff <= o_stb_in; pi_ff <= pi_in;
      end
      c_ff <= c_in; tr_ff <= tr_in; ti_ff <= ti_in; ar_ff <= ar_in; ai_ff <= ai_in;
      xr_ff <= xr_in; xi_ff <= xi_in; d_ff <= d_in; rr_ff <= rr_in;
      dneg_ff <= dneg_in; s1_ff <= s1_in; o_ff <= o_in;
      if (mwr) p_ff[pslot] <= p_in;
      if (we) mem[wa] <= wd;
      if (re) rd_ff <= mem[ra];
   end

   assign sts.done   = st_done;
   assign sts.t_zero = (tr_ff == 32'sd0) && (ti_ff == 32'sd0);
   assign rsp_strobe = o_stb_ff;
   assign rsp_data   = o_ff;
   // xr/xi feed mulsub products directly via registers
endmodule

@@ rtl/core/cmi_ctrl.sv @@
// ---------------------------------------------------------------------------
// cmi_ctrl : elimination sequencer
// Walks load, identity fill, forward scale/subtract, back elimination, emit.
// ---------------------------------------------------------------------------
module cmi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cmi_pkg::sts_type  sts,
   output logic              busy,
   output logic              cmd_go,
   output cmi_pkg::cmd_type  cmd,
   output logic              sing
);
   import cmi_pkg::*;

   state_type st_ff, st_in;
   logic [RW-1:0] i_ff, i_in, k_ff, k_in;
   logic [CW-1:0] j_ff, j_in;
   logic [LW-1:0] ld_ff, ld_in;
   logic          sg_ff, sg_in, wt_ff, wt_in;
   state_type     nx_ff, nx_in;

   localparam logic [RW-1:0] RMAX = RW'(SIZE - 1);
   localparam logic [CW-1:0] CMAX = CW'(NCOL - 1);

   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff; ld_in = ld_ff;
      sg_in = sg_ff; wt_in = wt_ff; nx_in = nx_ff;
      cmd_go = 1'b0; cmd = '0; busy = 1'b1;
      cmd.row = i_ff; cmd.col = j_ff; cmd.src = k_ff; cmd.pcol = CW'(k_ff);
      unique case (st_ff)
         ST_LOAD: begin
            busy = 1'b0;
            cmd.op = OP_LOAD;
            cmd.row = RW'(ld_ff / SIZE); cmd.col = CW'(ld_ff % SIZE);
            if (start) begin
               cmd_go = 1'b1;
               if (ld_ff == '0) sg_in = 1'b0;
               if (ld_ff == LW'(NELEM - 1)) begin
                  ld_in = '0; st_in = ST_IDENT;
                  i_in = '0; j_in = CW'(SIZE);
               end else ld_in = ld_ff + LW'(1);
            end
         end
         ST_IDENT: begin
            cmd.op = OP_IDENT; cmd_go = 1'b1;
            if (j_ff == CMAX) begin
               j_in = CW'(SIZE);
               if (i_ff == RMAX) begin
                  i_in = '0; k_in = '0; st_in = ST_SCALE_T;
               end else i_in = i_ff + 1'b1;
            end else j_in = j_ff + 1'b1;
         end
         ST_SCALE_T, ST_MS_T: begin
            if (!wt_ff) begin
               cmd.op = (st_ff == ST_MS_T) ? OP_MULSUB : OP_SCALE;
               cmd.get_t = 1'b1;
               cmd_go = 1'b1; wt_in = 1'b1;
            end else if (sts.done) begin
               wt_in = 1'b0; j_in = '0;
               if (st_ff == ST_SCALE_T && sts.t_zero) begin
                  sg_in = 1'b1;
                  st_in = ST_WAIT; // skip this row
               end else st_in = (st_ff == ST_MS_T) ? ST_MULSUB : ST_SCALE;
            end
         end
         ST_SCALE, ST_SUB, ST_MULSUB, ST_EMIT: begin
            unique case (st_ff)
               ST_SCALE: cmd.op = OP_SCALE;
               ST_SUB:   cmd.op = OP_SUB;
               ST_MULSUB: cmd.op = OP_MULSUB;
               default:  cmd.op = OP_EMIT;
            endcase
            if (st_ff == ST_SUB) cmd.src = k_ff - 1'b1;
            if (st_ff == ST_EMIT) begin
               cmd.col = j_ff + CW'(SIZE); cmd.src = i_ff;
               cmd.last = (i_ff == RMAX) && (j_ff == CW'(SIZE - 1));
            end
            if (!wt_ff) begin
               cmd_go = 1'b1; wt_in = 1'b1;
            end else if (sts.done) begin
               wt_in = 1'b0;
               if ((st_ff == ST_EMIT && j_ff == CW'(SIZE - 1)) ||
                   (st_ff != ST_EMIT && j_ff == CMAX)) begin
                  j_in = '0; st_in = ST_WAIT;
               end else j_in = j_ff + 1'b1;
            end
         end
         default: begin
            // ST_WAIT: pick the next row pass
            st_in = ST_LOAD;
            unique case (nx_ff)
               ST_SCALE_T: begin
                  // forward scale pass rows k..SIZE-1 at column k
                  if (i_ff != RMAX) begin
                     i_in = i_ff + 1'b1; st_in = ST_SCALE_T;
                  end else if (k_ff != RMAX) begin
                     k_in = k_ff + 1'b1; i_in = k_ff + 1'b1;
                     nx_in = ST_SUB; st_in = ST_SUB;
                  end else begin
                     k_in = RW'(1); i_in = '0; nx_in = ST_MS_T; st_in = ST_MS_T;
                  end
               end
               ST_SUB: begin
                  if (i_ff != RMAX) begin
                     i_in = i_ff + 1'b1; st_in = ST_SUB;
                  end else begin
                     i_in = k_ff; nx_in = ST_SCALE_T; st_in = ST_SCALE_T;
                  end
               end
               ST_MS_T: begin
                  if (i_ff + 1'b1 != k_ff) begin
                     i_in = i_ff + 1'b1; st_in = ST_MS_T;
                  end else if (k_ff != RMAX) begin
                     k_in = k_ff + 1'b1; i_in = '0; st_in = ST_MS_T;
                  end else begin
                     i_in = '0; j_in = '0; nx_in = ST_EMIT; st_in = ST_EMIT;
                  end
               end
               default: begin
                  if (i_ff != RMAX) begin
                     i_in = i_ff + 1'b1; st_in = ST_EMIT;
                  end else begin
                     nx_in = ST_SCALE_T; st_in = ST_LOAD;
                  end
               end
            endcase
         end
      endcase
      if (st_ff == ST_IDENT && st_in == ST_SCALE_T) nx_in = ST_SCALE_T;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; ld_ff <= '0; sg_ff <= 1'b0; wt_ff <= 1'b0;
         nx_ff <= ST_SCALE_T;
         i_ff <= '0; j_ff <= '0; k_ff <= '0;
      end else begin
         st_ff <= st_in; ld_ff <= ld_in; sg_ff <= sg_in; wt_ff <= wt_in;
         nx_ff <= nx_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      end
   end

   assign sing = sg_ff;
endmodule
